### hw/rtl/ukfq_pkg.sv
package ukfq_pkg;

  localparam int DEPTH     = 16;
  localparam int DATA_BITS = 32;
  localparam int KEY_W     = 32;
  localparam int FIELD_W   = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int STAT_W    = 3;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_ENQ   = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_DEQ   = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd4;

endpackage

### hw/rtl/ukfq_req_if.sv
interface ukfq_req_if;
  import ukfq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [KEY_W-1:0]   new_key;
  logic        [FIELD_W-1:0] new_data;

  modport source (output valid, output req_type, output new_key, output new_data,
                  input ready);
  modport sink   (input valid, input req_type, input new_key, input new_data,
                  output ready);
endinterface

### hw/rtl/ukfq_rsp_if.sv
interface ukfq_rsp_if;
  import ukfq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [STAT_W-1:0]  status;
  logic signed [KEY_W-1:0]   out_key;
  logic        [FIELD_W-1:0] out_data;
  logic        [CNT_W-1:0]   occupancy;
  logic                      is_empty;

  modport source (output valid, output status, output out_key, output out_data,
                  output occupancy, output is_empty, input ready);
  modport sink   (input valid, input status, input out_key, input out_data,
                  input occupancy, input is_empty, output ready);
endinterface

### hw/rtl/unique_key_fifo_queue.sv
// One request at a time: the next is taken only once the result of the last one has loaded
// into the output register. The key scan past the one shared key comparator sets how long
// an enqueue takes, and a stalled result holds off the next request.
// Reset (rst, synchronous, active high) empties the queue and the result register;
// entry memory contents are left as they are.
module unique_key_fifo_queue (
  input  logic       clk,
  input  logic       rst,
  ukfq_req_if.sink   req,
  ukfq_rsp_if.source rsp
);
  import ukfq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DEQ_RD,
    S_DEQ_FIN,
    S_PUSH
  } state_t;

  state_t state;

  // Queue bookkeeping
  logic [ADDR_W-1:0] head_ptr;
  logic [ADDR_W-1:0] tail_ptr;
  logic [CNT_W-1:0]  entry_count;

  // Captured request
  logic signed [KEY_W-1:0] key_q;
  logic [DATA_BITS-1:0]    data_q;

  // Scan sequencer
  logic [ADDR_W-1:0] scan_ptr;
  logic [ADDR_W-1:0] scan_ptr_next;
  logic [CNT_W-1:0]  idx;
  logic              cmp_vld;
  logic              issue;
  logic              match;

  // Entry memory with registered read
  logic [KEY_W-1:0]     key_mem  [DEPTH];
  logic [DATA_BITS-1:0] data_mem [DEPTH];
  logic [KEY_W-1:0]     rd_key;
  logic [DATA_BITS-1:0] rd_data;
  logic                 wr_en;

  // Pending result, waiting for the output register
  logic [STAT_W-1:0]  res_status;
  logic [KEY_W-1:0]   res_key;
  logic [FIELD_W-1:0] res_data;

  function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign req.ready     = (state == S_IDLE);
  assign scan_ptr_next = next_slot(scan_ptr);
  assign issue         = (idx < entry_count);
  // The one shared comparator: stored key read last cycle against the request key
  assign match         = cmp_vld && (rd_key == key_q);
  assign wr_en         = (state == S_SCAN) && !match && !issue && !cmp_vld &&
                         (entry_count != CNT_W'(DEPTH));

  // Entry memory: write at the tail on a successful enqueue, read at the scan slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[tail_ptr]  <= key_q;
      data_mem[tail_ptr] <= data_q;
    end
    rd_key  <= key_mem[scan_ptr];
    rd_data <= data_mem[scan_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_ptr    <= '0;
      tail_ptr    <= '0;
      entry_count <= '0;
      idx         <= '0;
      cmp_vld     <= 1'b0;
      rsp.valid   <= 1'b0;
    end else begin
      // Drop the result once the sink has taken it; a reload below keeps it up
      if (rsp.valid && rsp.ready && (state != S_PUSH)) begin
        rsp.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            key_q    <= req.new_key;
            data_q   <= DATA_BITS'(req.new_data);
            scan_ptr <= head_ptr;
            idx      <= '0;
            cmp_vld  <= 1'b0;
            res_key  <= '0;
            res_data <= '0;
            if (req.req_type == REQ_ENQ) begin
              state <= S_SCAN;
            end else if (entry_count == '0) begin
              res_status <= ST_EMPTY;
              state      <= S_PUSH;
            end else begin
              state <= S_DEQ_RD;
            end
          end
        end

        S_SCAN: begin
          if (match) begin
            // Key already held: reject, leave the queue untouched
            res_status <= ST_DUP;
            state      <= S_PUSH;
          end else if (!issue && !cmp_vld) begin
            // Every held entry compared without a hit
            if (entry_count == CNT_W'(DEPTH)) begin
              res_status <= ST_FULL;
            end else begin
              res_status  <= ST_ENQ;
              tail_ptr    <= next_slot(tail_ptr);
              entry_count <= entry_count + 1'b1;
            end
            state <= S_PUSH;
          end else begin
            // Advance the scan: issue the next read while comparing the last one
            cmp_vld <= issue;
            if (issue) begin
              idx      <= idx + 1'b1;
              scan_ptr <= scan_ptr_next;
            end
          end
        end

        S_DEQ_RD: begin
          // Head read issued this cycle; data lands next cycle
          state <= S_DEQ_FIN;
        end

        S_DEQ_FIN: begin
          res_status  <= ST_DEQ;
          res_key     <= FIELD_W'(rd_key);
          res_data    <= FIELD_W'(rd_data);
          head_ptr    <= next_slot(head_ptr);
          entry_count <= entry_count - 1'b1;
          state       <= S_PUSH;
        end

        S_PUSH: begin
          // Load the output register once it is free or being emptied
          if (!rsp.valid || rsp.ready) begin
            rsp.valid     <= 1'b1;
            rsp.status    <= res_status;
            rsp.out_key   <= res_key;
            rsp.out_data  <= res_data;
            rsp.occupancy <= entry_count;
            rsp.is_empty  <= (entry_count == '0);
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second request taken while one is in progress");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    entry_count == '0 |-> head_ptr == tail_ptr)
    else $error("empty queue with head and tail apart");

  a_full_ptrs: assert property (@(posedge clk) disable iff (rst)
    entry_count == CNT_W'(DEPTH) |-> head_ptr == tail_ptr)
    else $error("full queue with head and tail apart");

  a_rsp_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.is_empty == (rsp.occupancy == '0))
    else $error("empty flag disagrees with occupancy");

  a_no_write_on_dup: assert property (@(posedge clk) disable iff (rst)
    match |-> !wr_en)
    else $error("entry written on a duplicate key");

endmodule

### bench/unique_key_fifo_queue_tb.sv
module unique_key_fifo_queue_tb;
  import ukfq_pkg::*;

  // One request as the sender sees it, and one result as the predictor works it out.
  typedef struct packed {
    logic                      req_type;
    logic signed [KEY_W-1:0]   key;
    logic        [FIELD_W-1:0] data;
  } queue_request_t;

  typedef struct packed {
    logic        [STAT_W-1:0]  status;
    logic signed [KEY_W-1:0]   key;
    logic        [FIELD_W-1:0] data;
    logic        [CNT_W-1:0]   occupancy;
    logic                      is_empty;
  } queue_outcome_t;

  // A row of the directed table; pinned rows carry a result typed in by hand.
  typedef struct {
    queue_request_t rq;
    bit             pinned;
    queue_outcome_t typed_in;
  } stimulus_row_t;

  localparam int RANDOM_REQUESTS = 850;
  localparam int KEY_POOL        = 20;
  localparam int IDLE_PCT        = 35;
  localparam int REPORT_CAP      = 100;

  logic clk;
  logic rst;

  ukfq_req_if req_bus ();
  ukfq_rsp_if rsp_bus ();

  unique_key_fifo_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // Shadow of the queue: entry slots, pointers and the number of entries held.
  logic signed [KEY_W-1:0]     key_shadow  [DEPTH];
  logic        [DATA_BITS-1:0] data_shadow [DEPTH];
  int                          head_shadow;
  int                          tail_shadow;
  int                          held_count;

  queue_outcome_t pending_outcomes [$];
  stimulus_row_t  directed_rows [$];
  logic signed [KEY_W-1:0] key_pool [KEY_POOL];

  int idle_pct;
  int fail_count;
  int requests_sent;
  int status_tally [8];

  // Free-running clock, period 8.
  always #4 clk = ~clk;

  // Apply one request to the shadow queue and return the result it must give.
  // Enqueue: scan every held entry from head to tail for the key first, so a
  // duplicate wins over a full queue. Dequeue: pop the head, or report empty.
  function automatic queue_outcome_t resolve_request(input queue_request_t rq);
    queue_outcome_t o;
    bit             seen;
    int             slot;
    o    = '0;
    seen = 1'b0;
    slot = head_shadow;
    if (rq.req_type == REQ_ENQ) begin
      for (int i = 0; i < held_count; i++) begin
        if (key_shadow[slot] == rq.key) seen = 1'b1;
        slot = (slot + 1) % DEPTH;
      end
      if (seen) begin
        o.status = ST_DUP;
      end else if (held_count >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        key_shadow[tail_shadow]  = rq.key;
        data_shadow[tail_shadow] = rq.data[DATA_BITS-1:0];
        tail_shadow              = (tail_shadow + 1) % DEPTH;
        held_count++;
        o.status = ST_ENQ;
      end
    end else begin
      if (held_count == 0) begin
        o.status = ST_EMPTY;
      end else begin
        o.key       = key_shadow[head_shadow];
        o.data      = FIELD_W'(data_shadow[head_shadow]);
        head_shadow = (head_shadow + 1) % DEPTH;
        held_count--;
        o.status = ST_DEQ;
      end
    end
    o.occupancy = CNT_W'(held_count);
    o.is_empty  = (held_count == 0);
    return o;
  endfunction

  function automatic void add_row(input logic req_type, input logic [KEY_W-1:0] key,
                                  input logic [FIELD_W-1:0] data, input bit pinned,
                                  input queue_outcome_t typed_in);
    stimulus_row_t row;
    row.rq       = '{req_type, key, data};
    row.pinned   = pinned;
    row.typed_in = typed_in;
    directed_rows.push_back(row);
  endfunction

  // Drive one request, entered and left at a falling edge. Idle cycles hold
  // valid low; valid is raised once and held until the request is taken at a
  // rising edge with ready high. The expectation is queued on acceptance.
  task automatic send_request(input queue_request_t rq, input bit pinned,
                              input queue_outcome_t typed_in);
    queue_outcome_t want;
    while ($urandom_range(99) < idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= rq.req_type;
    req_bus.new_key  <= rq.key;
    req_bus.new_data <= rq.data;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    // Advance the shadow on every request; a pinned row replaces the result only.
    want = resolve_request(rq);
    if (pinned) want = typed_in;
    pending_outcomes.push_back(want);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      else if (fail_count == REPORT_CAP + 1)
        $display("%0t: further mismatch reports suppressed", $time);
    end
  endtask

  // Result sink: ready idles at random, changing on the falling edge only.
  always @(negedge clk) begin
    if (rst) rsp_bus.ready <= 1'b0;
    else rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
  end

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    queue_outcome_t want;
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      status_tally[rsp_bus.status]++;
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing outstanding, expected none, actual status %0d key %h",
                 $time, rsp_bus.status, rsp_bus.out_key);
      end else begin
        want = pending_outcomes.pop_front();
        flag_field("status",    32'(want.status),    32'(rsp_bus.status));
        flag_field("out_key",   32'(want.key),       32'(rsp_bus.out_key));
        flag_field("out_data",  32'(want.data),      32'(rsp_bus.out_data));
        flag_field("occupancy", 32'(want.occupancy), 32'(rsp_bus.occupancy));
        flag_field("is_empty",  32'(want.is_empty),  32'(rsp_bus.is_empty));
      end
    end
  end

  // Hard limit on the run, several times the slowest correct run.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    queue_request_t rq;
    int             pick;
    int             enq_bias;

    clk              = 1'b0;
    rst              = 1'b1;
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_ENQ;
    req_bus.new_key  = '0;
    req_bus.new_data = '0;
    rsp_bus.ready    = 1'b0;
    idle_pct         = IDLE_PCT;
    fail_count       = 0;
    requests_sent    = 0;
    head_shadow      = 0;
    tail_shadow      = 0;
    held_count       = 0;
    enq_bias         = 50;
    foreach (status_tally[i]) status_tally[i] = 0;

    // Key pool: the extremes first, the rest random. Drawing from a small pool
    // makes duplicate keys and re-use of dequeued keys common.
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7FFF_FFFF;
    key_pool[2] = 32'sh0000_0000;
    key_pool[3] = 32'shFFFF_FFFF;
    key_pool[4] = 32'sh0000_0001;
    for (int i = 5; i < KEY_POOL; i++) key_pool[i] = $urandom();

    // Directed table. Empty dequeue after reset, most negative key, duplicate of
    // the head, largest key and payload, reuse of a key once dequeued, duplicate
    // in mid-queue, fill to the bound with a wrap of the tail, full rejection of a new
    // key, duplicate check ahead of the full check against the tail entry, then a refill.
    add_row(REQ_DEQ, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_EMPTY, 0, 0, 0, 1'b1});
    add_row(REQ_ENQ, 32'h8000_0000, 32'h0000_0000, 1'b1, '{ST_ENQ, 0, 0, 1, 1'b0});
    add_row(REQ_ENQ, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_DUP, 0, 0, 1, 1'b0});
    add_row(REQ_ENQ, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_ENQ, 0, 0, 2, 1'b0});
    add_row(REQ_ENQ, 32'h0000_0000, 32'h5A5A_5A5A, 1'b1, '{ST_ENQ, 0, 0, 3, 1'b0});
    add_row(REQ_ENQ, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b1, '{ST_ENQ, 0, 0, 4, 1'b0});
    add_row(REQ_DEQ, 32'h0000_0000, 32'h0000_0000, 1'b1,
            '{ST_DEQ, 32'sh8000_0000, 32'h0000_0000, 3, 1'b0});
    add_row(REQ_ENQ, 32'h8000_0000, 32'h1234_5678, 1'b0, '0);
    add_row(REQ_ENQ, 32'h0000_0000, 32'hDEAD_BEEF, 1'b1, '{ST_DUP, 0, 0, 4, 1'b0});
    for (int i = 0; i < 12; i++)
      add_row(REQ_ENQ, 32'h10 + i, ~(32'h1 << i), 1'b0, '0);
    add_row(REQ_ENQ, 32'h7FFF_FFFE, 32'h0F0F_0F0F, 1'b1, '{ST_FULL, 0, 0, 16, 1'b0});
    add_row(REQ_ENQ, 32'h0000_001B, 32'h0F0F_0F0F, 1'b1, '{ST_DUP, 0, 0, 16, 1'b0});
    add_row(REQ_DEQ, 32'h0000_0000, 32'h0000_0000, 1'b1,
            '{ST_DEQ, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 15, 1'b0});
    add_row(REQ_ENQ, 32'h7FFF_FFFE, 32'h0F0F_0F0F, 1'b1, '{ST_ENQ, 0, 0, 16, 1'b0});

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].rq, directed_rows[i].pinned, directed_rows[i].typed_in);

    // Random part in segments of forty requests, each biased towards filling,
    // draining or a balanced mix, so the queue keeps hitting full and empty and
    // both pointers wrap many times. A stretch in the middle runs with no idling.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       enq_bias = 85;
          1:       enq_bias = 20;
          default: enq_bias = 55;
        endcase
      end
      idle_pct = (n >= 350 && n < 550) ? 0 : IDLE_PCT;

      rq.req_type = ($urandom_range(99) < enq_bias) ? REQ_ENQ : REQ_DEQ;
      pick = $urandom_range(99);
      // Pick a key held somewhere in the queue, one from the pool, or a fresh one.
      if (pick < 25 && held_count > 0)
        rq.key = key_shadow[(head_shadow + $urandom_range(held_count - 1)) % DEPTH];
      else if (pick < 75)
        rq.key = key_pool[$urandom_range(KEY_POOL - 1)];
      else
        rq.key = $urandom();
      rq.data = $urandom();
      send_request(rq, 1'b0, '0);
    end
    req_bus.valid <= 1'b0;
    idle_pct = IDLE_PCT;

    // Drain: wait for every outstanding result, then allow a full key scan more.
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Run covered %0d requests (%0d from the directed table): %0d enqueued, %0d duplicate,",
             requests_sent, directed_rows.size(), status_tally[ST_ENQ], status_tally[ST_DUP]);
    $display("  %0d full, %0d dequeued and %0d empty rejections, with random gaps on both sides.",
             status_tally[ST_FULL], status_tally[ST_DEQ], status_tally[ST_EMPTY]);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
